### sv/assert_macros.svh
// Assertion macros shared by the RTL of the ALU execute block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clk edge, quiet during reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property that must also hold while reset is asserted.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/alu8_pkg.sv
// Package for the 8-bit ALU execute block: opcode codes, result types and
// the ALU and INC/DEC flag functions. Depends on nothing.
`default_nettype none

package alu8_pkg;

    localparam logic [1:0] PRE_NONE = 2'd0;
    localparam logic [1:0] PRE_IX   = 2'd1;
    localparam logic [1:0] PRE_IY   = 2'd2;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_ADC = 3'd1;
    localparam logic [2:0] OP_SUB = 3'd2;
    localparam logic [2:0] OP_SBC = 3'd3;
    localparam logic [2:0] OP_AND = 3'd4;
    localparam logic [2:0] OP_XOR = 3'd5;
    localparam logic [2:0] OP_OR  = 3'd6;
    localparam logic [2:0] OP_CP  = 3'd7;

    localparam logic [2:0] R_H   = 3'd4;
    localparam logic [2:0] R_L   = 3'd5;
    localparam logic [2:0] R_MEM = 3'd6;
    localparam logic [2:0] R_A   = 3'd7;

    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 56;

    typedef struct packed {
        logic [7:0] res;
        logic [7:0] flags;
    } alu_res_t;

    function automatic alu_res_t alu_exec(input logic [2:0] op, input logic [7:0] a,
                                          input logic [7:0] b, input logic cf);
        alu_res_t   o;
        logic [8:0] r9;
        logic [7:0] r;
        logic       cin;
        cin = ((op == OP_ADC) || (op == OP_SBC)) ? cf : 1'b0;
        r9  = 9'd0;
        r   = 8'd0;
        o   = '0;
        case (op)
            OP_ADD, OP_ADC:
            begin
                r9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
                r  = r9[7:0];
                o.res   = r;
                o.flags = {r[7], r == 8'd0, r[5], a[4] ^ b[4] ^ r[4], r[3],
                           (a[7] ^ r[7]) & (b[7] ^ r[7]), 1'b0, r9[8]};
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                r9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
                r  = r9[7:0];
                o.res = (op == OP_CP) ? a : r;
                o.flags = {r[7], r == 8'd0,
                           (op == OP_CP) ? b[5] : r[5], a[4] ^ b[4] ^ r[4],
                           (op == OP_CP) ? b[3] : r[3],
                           (a[7] ^ b[7]) & (a[7] ^ r[7]), 1'b1, r9[8]};
            end
            OP_AND:
            begin
                r = a & b;
                o.res   = r;
                o.flags = {r[7], r == 8'd0, r[5], 1'b1, r[3], ~^r, 2'b00};
            end
            OP_XOR:
            begin
                r = a ^ b;
                o.res   = r;
                o.flags = {r[7], r == 8'd0, r[5], 1'b0, r[3], ~^r, 2'b00};
            end
            default:
            begin
                r = a | b;
                o.res   = r;
                o.flags = {r[7], r == 8'd0, r[5], 1'b0, r[3], ~^r, 2'b00};
            end
        endcase
        return o;
    endfunction

    function automatic alu_res_t inc_dec(input logic dec, input logic [7:0] v,
                                         input logic cf);
        alu_res_t   o;
        logic [7:0] r;
        r = dec ? (v - 8'd1) : (v + 8'd1);
        o.res = r;
        if (dec)
            o.flags = {r[7], r == 8'd0, r[5], v[3:0] == 4'h0, r[3], v == 8'h80, 1'b1, cf};
        else
            o.flags = {r[7], r == 8'd0, r[5], v[3:0] == 4'hF, r[3], v == 8'h7F, 1'b0, cf};
        return o;
    endfunction

endpackage

`default_nettype wire

### sv/alu8_instruction_group_execute.sv
// Top level of the 8-bit ALU execute block: register file memory, decode,
// ALU and output register. Depends on alu8_pkg and assert_macros.svh.
//
// Channel  Dir  Fields (low bit up)
// s_*      in   tuser: prefix_sel; tdata: opcode, operand_byte, mem_data
// m_*      out  tdata: acc_out, flags_out, mem_addr, mem_rd, mem_wr,
//               mem_wdata, insn_length, cycle_count
//
// One item per cycle sustained unless the output stalls. The register file read
// is issued at accept (synchronous memory) as the item enters the execute stage;
// execute and write-back happen as the item moves to the output register.
// A write landing on the entry just read is forwarded into the next item.
// rst_n clears valid bits of the register file, A/H/L, flags, IX and IY.
// A stalled result holds; s_tready stays high while the output can drain.
`default_nettype none

module alu8_instruction_group_execute (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // opcode, operand_byte, mem_data
    input  wire logic [1:0]  s_tuser,  // prefix_sel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata   // acc_out, flags_out, mem_addr, mem_rd,
                                       // mem_wr, mem_wdata, insn_length, cycle_count
);

    // Register file memory plus valid bits (unwritten entries read as zero)
    logic [7:0] rf_mem [8];
    logic [7:0] rf_valid_reg;
    logic [7:0] rf_q_reg;
    logic       rf_q_valid_reg;
    logic       fwd_hit_reg;
    logic [7:0] fwd_data_reg;

    // Shadow copies of A, H, L and the other architectural state
    logic [7:0]  a_reg, h_reg, l_reg, f_reg;
    logic [15:0] ix_reg, iy_reg;

    // Execute stage holding register
    logic        v1_reg;
    logic [1:0]  pre_reg;
    logic [7:0]  opc_reg, nb_reg, md_reg;

    // Output register
    logic        vo_reg;
    logic [55:0] out_reg;

    logic       advance;
    logic       accept;
    logic [2:0] rd_idx;
    logic [7:0] in_opc;

    assign advance  = !vo_reg || m_tready;
    assign s_tready = !v1_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign in_opc   = s_tdata[7:0];
    assign rd_idx   = (in_opc[7:6] == 2'b10) ? in_opc[2:0] : in_opc[5:3];

    // Decode and execute
    logic [2:0]  op, src;
    logic        is_alu, is_imm, is_id, dec;
    logic [7:0]  reg_val, mem_reg_val, opnd, wdata;
    logic [15:0] idx, eff;
    logic [15:0] addr;
    logic        rd, wr, use_alu, known;
    logic [1:0]  len;
    logic [4:0]  cyc;
    logic        reg_we, ix_we, iy_we, a_we;
    logic [2:0]  reg_idx;
    logic [15:0] idx_new;
    alu8_pkg::alu_res_t ar, ir;
    logic [7:0]  acc_new, f_new, id_res;
    logic        do_write;

    always_comb
    begin
        op     = opc_reg[5:3];
        src    = opc_reg[2:0];
        is_alu = opc_reg[7:6] == 2'b10;
        is_imm = (opc_reg & 8'hC7) == 8'hC6;
        is_id  = (opc_reg & 8'hC6) == 8'h04;
        dec    = opc_reg[0];
        idx    = (pre_reg == alu8_pkg::PRE_IX) ? ix_reg : iy_reg;
        eff    = idx + {{8{nb_reg[7]}}, nb_reg};

        mem_reg_val = fwd_hit_reg ? fwd_data_reg : (rf_q_valid_reg ? rf_q_reg : 8'd0);
        case (is_alu ? src : op)
            alu8_pkg::R_A: reg_val = a_reg;
            alu8_pkg::R_H: reg_val = h_reg;
            alu8_pkg::R_L: reg_val = l_reg;
            default:       reg_val = mem_reg_val;
        endcase

        addr = 16'd0; rd = 1'b0; wr = 1'b0; len = 2'd0; cyc = 5'd0;
        use_alu = 1'b0; known = 1'b0; opnd = 8'd0;
        reg_we = 1'b0; ix_we = 1'b0; iy_we = 1'b0; reg_idx = op;
        if (pre_reg == alu8_pkg::PRE_NONE)
        begin
            if (is_alu)
            begin
                use_alu = 1'b1; known = 1'b1; len = 2'd1;
                if (src == alu8_pkg::R_MEM)
                begin
                    addr = {h_reg, l_reg}; rd = 1'b1; opnd = md_reg; cyc = 5'd7;
                end
                else
                begin
                    opnd = reg_val; cyc = 5'd4;
                end
            end
            else if (is_imm)
            begin
                use_alu = 1'b1; known = 1'b1; opnd = nb_reg; len = 2'd2; cyc = 5'd7;
            end
            else if (is_id)
            begin
                known = 1'b1; len = 2'd1;
                if (op == alu8_pkg::R_MEM)
                begin
                    addr = {h_reg, l_reg}; rd = 1'b1; wr = 1'b1; opnd = md_reg;
                    cyc = 5'd11;
                end
                else
                begin
                    opnd = reg_val; reg_we = 1'b1; cyc = 5'd4;
                end
            end
        end
        else if ((pre_reg == alu8_pkg::PRE_IX) || (pre_reg == alu8_pkg::PRE_IY))
        begin
            if (is_alu && (src == alu8_pkg::R_MEM))
            begin
                use_alu = 1'b1; known = 1'b1; addr = eff; rd = 1'b1; opnd = md_reg;
                len = 2'd3; cyc = 5'd19;
            end
            else if (is_alu && ((src == alu8_pkg::R_H) || (src == alu8_pkg::R_L)))
            begin
                use_alu = 1'b1; known = 1'b1;
                opnd = (src == alu8_pkg::R_L) ? idx[7:0] : idx[15:8];
                len = 2'd2; cyc = 5'd10;
            end
            else if (is_id && (op == alu8_pkg::R_MEM))
            begin
                known = 1'b1; addr = eff; rd = 1'b1; wr = 1'b1; opnd = md_reg;
                len = 2'd3; cyc = 5'd23;
            end
            else if (is_id && ((op == alu8_pkg::R_H) || (op == alu8_pkg::R_L)))
            begin
                known = 1'b1; opnd = (op == alu8_pkg::R_L) ? idx[7:0] : idx[15:8];
                ix_we = (pre_reg == alu8_pkg::PRE_IX);
                iy_we = (pre_reg == alu8_pkg::PRE_IY);
                len = 2'd2; cyc = 5'd10;
            end
        end

        ar     = alu8_pkg::alu_exec(op, a_reg, opnd, f_reg[0]);
        ir     = alu8_pkg::inc_dec(dec, opnd, f_reg[0]);
        id_res = ir.res;
        wdata  = wr ? id_res : 8'd0;
        idx_new = (op == alu8_pkg::R_L) ? {idx[15:8], id_res} : {id_res, idx[7:0]};

        // ALU results land in A; register INC/DEC may also target A
        a_we = use_alu || (reg_we && (reg_idx == alu8_pkg::R_A));
        if (use_alu)
        begin
            reg_we  = 1'b1;
            reg_idx = alu8_pkg::R_A;
        end
        acc_new = a_we ? (use_alu ? ar.res : id_res) : a_reg;
        f_new   = known ? (use_alu ? ar.flags : ir.flags) : f_reg;
    end

    assign do_write = v1_reg && advance;

    // Register file memory: one read port at accept, one write port at retire
    always_ff @(posedge clk)
    begin
        if (accept)
            rf_q_reg <= rf_mem[rd_idx];
        if (do_write && reg_we)
            rf_mem[reg_idx] <= acc_new & {8{use_alu}} | id_res & {8{!use_alu}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg   <= 8'd0;
            rf_q_valid_reg <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            v1_reg         <= 1'b0;
            vo_reg         <= 1'b0;
            a_reg          <= 8'd0;
            h_reg          <= 8'd0;
            l_reg          <= 8'd0;
            f_reg          <= 8'd0;
            ix_reg         <= 16'd0;
            iy_reg         <= 16'd0;
        end
        else
        begin
            if (accept)
            begin
                rf_q_valid_reg <= rf_valid_reg[rd_idx];
                // Forward a write that retires in the same cycle as the read
                fwd_hit_reg    <= do_write && reg_we && (reg_idx == rd_idx);
            end
            if (s_tready)
                v1_reg <= s_tvalid;
            if (advance)
                vo_reg <= v1_reg;
            if (do_write)
            begin
                f_reg <= f_new;
                if (reg_we)
                    rf_valid_reg[reg_idx] <= 1'b1;
                if (a_we)
                    a_reg <= acc_new;
                if (reg_we && (reg_idx == alu8_pkg::R_H))
                    h_reg <= id_res;
                if (reg_we && (reg_idx == alu8_pkg::R_L))
                    l_reg <= id_res;
                if (ix_we)
                    ix_reg <= idx_new;
                if (iy_we)
                    iy_reg <= idx_new;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pre_reg <= s_tuser;
            opc_reg <= s_tdata[7:0];
            nb_reg  <= s_tdata[15:8];
            md_reg  <= s_tdata[23:16];
            fwd_data_reg <= acc_new & {8{use_alu}} | id_res & {8{!use_alu}};
        end
        if (do_write)
            out_reg <= {7'd0, cyc, len, wdata, wr, rd, addr, f_new, acc_new};
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = out_reg;

    `include "assert_macros.svh"

    `ASSERT_CLK(a_wr_needs_rd, (vo_reg |-> (!out_reg[33] || out_reg[32])), "write without read")
    `ASSERT_CLK(a_unknown_quiet, (vo_reg && (out_reg[43:42] == 2'd0) |-> ((out_reg[48:44] == 5'd0) && !out_reg[32])), "unknown opcode has side effects")
    `ASSERT_ALWAYS(a_ready_only_stalled, (!s_tready |-> (v1_reg && vo_reg && !m_tready)), "ready low without stall")
    `ASSERT_CLK(a_accept_fills, ((s_tvalid && s_tready) |=> v1_reg), "accepted item lost")

endmodule

`default_nettype wire
